// File: design/rcmc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rcmc_pkg;

  typedef enum logic [1:0] {
    OP_MAP_WRITE   = 2'd0,
    OP_CONST_WRITE = 2'd1,
    OP_QUERY       = 2'd2,
    OP_NONE        = 2'd3
  } opcode_t;

  localparam logic CFG_MAPPING_COUNT  = 1'b0;
  localparam logic CFG_CONSTANT_COUNT = 1'b1;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [5:0]  entry_index;
    logic [63:0] entry_start;
    logic [63:0] entry_limit;
    logic        entry_readable;
    logic        entry_writable;
    logic [63:0] query_addr;
    logic [31:0] query_size;
  } in_item_t;

  typedef struct packed {
    logic is_query_result;
    logic span_constant;
    logic span_wraps;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAP_RD,
    ST_MAP_CHK,
    ST_REGION,
    ST_CON_RD,
    ST_CON_CHK,
    ST_CON_STEP,
    ST_NEXT_REGION,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic start;        // latch query span
    logic map_scan_clr; // restart mapping scan at entry 0
    logic map_scan_inc;
    logic con_scan_clr;
    logic con_scan_inc;
    logic region_take;  // latch matched mapping entry, set sub end
    logic con_take;     // advance cursor past matched constant region
    logic map_advance;  // cursor to region end
    logic map_pass_inc;
    logic con_pass_inc;
    logic con_pass_clr;
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic map_scan_end;  // index reached used count
    logic map_hit;       // current registered entry matches cursor
    logic region_ok;     // readable
    logic region_wr;
    logic con_scan_end;
    logic con_hit;
    logic con_top;       // matched constant region reaches the top
    logic cursor_done;   // cursor >= span end
    logic sub_done;      // cursor >= sub end
    logic map_pass_over; // pass > used
    logic con_pass_over;
  } stat_t;

endpackage
`default_nettype wire

// File: design/rcmc_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module rcmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// File: design/rcmc_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module rcmc_datapath #(
  parameter int MAP_ENTRIES   = 64,
  parameter int CONST_ENTRIES = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [6:0]        cfg_data,
  input  wire logic              load_en,
  input  wire rcmc_pkg::in_item_t item,
  input  wire rcmc_pkg::ctrl_t   ctrl,
  output rcmc_pkg::stat_t        stat
);
  localparam int MAW = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
  localparam int CAW = (CONST_ENTRIES > 1) ? $clog2(CONST_ENTRIES) : 1;
  localparam int MCW = $clog2(MAP_ENTRIES + 2);
  localparam int CCW = $clog2(CONST_ENTRIES + 2);

  logic [6:0] mapping_count;
  logic [4:0] constant_count;
  logic [MCW-1:0] map_used;
  logic [CCW-1:0] con_used;

  always_ff @(posedge clk) begin
    if (rst) begin
      mapping_count  <= '0;
      constant_count <= '0;
    end else if (cfg_we) begin
      if (cfg_index == rcmc_pkg::CFG_MAPPING_COUNT) begin
        mapping_count <= cfg_data;
      end else begin
        constant_count <= cfg_data[4:0];
      end
    end
  end

  always_comb begin
    if (32'(mapping_count) > MAP_ENTRIES) begin
      map_used = MCW'(MAP_ENTRIES);
    end else begin
      map_used = MCW'(mapping_count);
    end
    if (32'(constant_count) > CONST_ENTRIES) begin
      con_used = CCW'(CONST_ENTRIES);
    end else begin
      con_used = CCW'(constant_count);
    end
  end

  // table writes
  logic map_we, con_we;
  logic [MCW-1:0] map_idx;
  logic [CCW-1:0] con_idx;
  logic [129:0] map_rdata;
  logic [127:0] con_rdata;

  assign map_we = load_en && item.opcode == rcmc_pkg::OP_MAP_WRITE
                  && 32'(item.entry_index) < MAP_ENTRIES;
  assign con_we = load_en && item.opcode == rcmc_pkg::OP_CONST_WRITE
                  && 32'(item.entry_index) < CONST_ENTRIES;

  rcmc_ram #(.WIDTH(130), .DEPTH(MAP_ENTRIES)) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (MAW'(item.entry_index)),
    .wdata ({item.entry_start, item.entry_limit, item.entry_readable,
             item.entry_writable}),
    .raddr (map_idx[MAW-1:0]),
    .rdata (map_rdata)
  );

  rcmc_ram #(.WIDTH(128), .DEPTH(CONST_ENTRIES)) u_con_ram (
    .clk   (clk),
    .we    (con_we),
    .waddr (CAW'(item.entry_index)),
    .wdata ({item.entry_start, item.entry_limit}),
    .raddr (con_idx[CAW-1:0]),
    .rdata (con_rdata)
  );

  logic [63:0] cursor, span_end, sub_end, reg_end;
  logic [64:0] con_sum;
  logic reg_rd, reg_wr, con_top;
  logic [MCW-1:0] map_pass;
  logic [CCW-1:0] con_pass;
  logic [63:0] m_start, m_end, c_start, c_size;

  assign m_start = map_rdata[129:66];
  assign m_end   = map_rdata[65:2];
  assign c_start = con_rdata[127:64];
  assign c_size  = con_rdata[63:0];
  assign con_sum = {1'b0, c_start} + {1'b0, c_size};

  always_ff @(posedge clk) begin
    if (rst) begin
      map_idx  <= '0;
      con_idx  <= '0;
      map_pass <= '0;
      con_pass <= '0;
    end else begin
      if (ctrl.map_scan_clr) begin
        map_idx <= '0;
      end else if (ctrl.map_scan_inc) begin
        map_idx <= map_idx + 1'b1;
      end
      if (ctrl.con_scan_clr) begin
        con_idx <= '0;
      end else if (ctrl.con_scan_inc) begin
        con_idx <= con_idx + 1'b1;
      end
      if (ctrl.start) begin
        map_pass <= '0;
      end else if (ctrl.map_pass_inc) begin
        map_pass <= map_pass + 1'b1;
      end
      if (ctrl.con_pass_clr) begin
        con_pass <= '0;
      end else if (ctrl.con_pass_inc) begin
        con_pass <= con_pass + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      cursor   <= item.query_addr;
      span_end <= item.query_addr + 64'(item.query_size);
    end else if (ctrl.con_take) begin
      cursor <= con_sum[63:0];
    end else if (ctrl.map_advance) begin
      cursor <= reg_end;
    end
    if (ctrl.region_take) begin
      reg_end <= m_end;
      reg_rd  <= map_rdata[1];
      reg_wr  <= map_rdata[0];
      sub_end <= (m_end < span_end) ? m_end : span_end;
    end
    if (ctrl.con_take) begin
      con_top <= con_sum[64];
    end
  end

  // the constant walk moves the region cursor; the region end restores it
  assign stat.map_scan_end  = map_idx >= map_used;
  assign stat.map_hit       = m_start <= cursor && cursor < m_end;
  assign stat.region_ok     = reg_rd;
  assign stat.region_wr     = reg_wr;
  assign stat.con_scan_end  = con_idx >= con_used;
  assign stat.con_hit       = cursor >= c_start && (cursor - c_start) < c_size;
  assign stat.con_top       = con_top;
  assign stat.cursor_done   = cursor >= span_end;
  assign stat.sub_done      = cursor >= sub_end;
  assign stat.map_pass_over = map_pass > map_used;
  assign stat.con_pass_over = con_pass > con_used;
endmodule
`default_nettype wire

// File: design/rcmc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module rcmc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire rcmc_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output rcmc_pkg::out_item_t    out_data,
  output logic                   load_en,
  output rcmc_pkg::ctrl_t        ctrl,
  input  wire rcmc_pkg::stat_t   stat
);
  rcmc_pkg::state_t state, state_next;
  logic in_acc, finish, pass_val;

  assign in_stall = state != rcmc_pkg::ST_IDLE || (out_valid && out_stall);
  assign in_acc   = in_valid && !in_stall;
  assign load_en  = in_acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rcmc_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (finish || (in_acc && !(in_data.opcode == rcmc_pkg::OP_QUERY
                                 && state_next != rcmc_pkg::ST_IDLE))) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_data <= '{is_query_result: 1'b1, span_constant: pass_val, span_wraps: 1'b0};
    end else if (in_acc && state_next == rcmc_pkg::ST_IDLE) begin
      out_data.is_query_result <= in_data.opcode == rcmc_pkg::OP_QUERY;
      out_data.span_constant   <= in_data.opcode == rcmc_pkg::OP_QUERY
                                  && in_data.query_size == '0;
      out_data.span_wraps      <= in_data.opcode == rcmc_pkg::OP_QUERY
                                  && in_data.query_size != '0;
    end
  end

  logic [64:0] q_sum;
  assign q_sum = {1'b0, in_data.query_addr} + 65'(in_data.query_size);

  always_comb begin
    state_next = state;
    ctrl       = '0;
    finish     = 1'b0;
    pass_val   = 1'b0;
    unique case (state)
      rcmc_pkg::ST_IDLE: begin
        if (in_acc && in_data.opcode == rcmc_pkg::OP_QUERY
            && in_data.query_size != '0 && !q_sum[64]) begin
          ctrl.start        = 1'b1;
          ctrl.map_scan_clr = 1'b1;
          state_next        = rcmc_pkg::ST_MAP_RD;
        end
      end
      rcmc_pkg::ST_MAP_RD: begin
        // outer pass guard, then wait for the registered table read
        if (stat.cursor_done) begin
          finish = 1'b1; pass_val = 1'b1; state_next = rcmc_pkg::ST_IDLE;
        end else if (stat.map_pass_over || stat.map_scan_end) begin
          finish = 1'b1; state_next = rcmc_pkg::ST_IDLE;
        end else begin
          state_next = rcmc_pkg::ST_MAP_CHK;
        end
      end
      rcmc_pkg::ST_MAP_CHK: begin
        if (stat.map_hit) begin
          ctrl.region_take = 1'b1;
          state_next       = rcmc_pkg::ST_REGION;
        end else begin
          ctrl.map_scan_inc = 1'b1;
          state_next        = rcmc_pkg::ST_MAP_RD;
        end
      end
      rcmc_pkg::ST_REGION: begin
        if (!stat.region_ok) begin
          finish = 1'b1; state_next = rcmc_pkg::ST_IDLE;
        end else if (stat.region_wr) begin
          ctrl.con_scan_clr = 1'b1;
          ctrl.con_pass_clr = 1'b1;
          state_next        = rcmc_pkg::ST_CON_RD;
        end else begin
          state_next = rcmc_pkg::ST_NEXT_REGION;
        end
      end
      rcmc_pkg::ST_CON_RD: begin
        if (stat.sub_done) begin
          state_next = rcmc_pkg::ST_NEXT_REGION;
        end else if (stat.con_pass_over || stat.con_scan_end) begin
          finish = 1'b1; state_next = rcmc_pkg::ST_IDLE;
        end else begin
          state_next = rcmc_pkg::ST_CON_CHK;
        end
      end
      rcmc_pkg::ST_CON_CHK: begin
        if (stat.con_hit) begin
          ctrl.con_take = 1'b0;
          state_next    = rcmc_pkg::ST_CON_STEP;
        end else begin
          ctrl.con_scan_inc = 1'b1;
          state_next        = rcmc_pkg::ST_CON_RD;
        end
      end
      rcmc_pkg::ST_CON_STEP: begin
        // registered sum is captured here from the still-held read data
        ctrl.con_take = 1'b1;
        state_next    = rcmc_pkg::ST_DONE;
      end
      rcmc_pkg::ST_DONE: begin
        if (stat.con_top) begin
          state_next = rcmc_pkg::ST_NEXT_REGION;
        end else begin
          ctrl.con_pass_inc = 1'b1;
          ctrl.con_scan_clr = 1'b1;
          state_next        = rcmc_pkg::ST_CON_RD;
        end
      end
      rcmc_pkg::ST_NEXT_REGION: begin
        ctrl.map_advance  = 1'b1;
        ctrl.map_pass_inc = 1'b1;
        ctrl.map_scan_clr = 1'b1;
        state_next        = rcmc_pkg::ST_MAP_RD;
      end
      default: state_next = rcmc_pkg::ST_IDLE;
    endcase
  end

  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    state != rcmc_pkg::ST_IDLE |-> in_stall) else $error("busy without stall");
  a_finish_idle: assert property (@(posedge clk) disable iff (rst)
    finish |=> state == rcmc_pkg::ST_IDLE) else $error("finish not idle");
  a_finish_valid: assert property (@(posedge clk) disable iff (rst)
    finish |=> out_valid) else $error("result lost");
endmodule
`default_nettype wire

// File: design/range_constant_memory_checker_core.sv
`timescale 1ns / 1ps
`default_nettype none
// channel  valid      stall       payload
// in       in_valid   in_stall    in_data  (rcmc_pkg::in_item_t)
// out      out_valid  out_stall   out_data (rcmc_pkg::out_item_t)
// cfg      cfg_we     -           cfg_index, cfg_data
// loads and trivial queries answer the cycle after acceptance; a query reads
// and checks mapping entries in turn, and in each writable region taken reads
// and checks constant entries in turn, stepping past each match, one table read a cycle
// synchronous reset clears counts and control; table contents are kept
// a held result blocks new transactions until taken
module range_constant_memory_checker_core #(
  parameter int MAP_ENTRIES   = 64,
  parameter int CONST_ENTRIES = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire rcmc_pkg::in_item_t in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output rcmc_pkg::out_item_t     out_data,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [6:0]         cfg_data
);
  rcmc_pkg::ctrl_t ctrl;
  rcmc_pkg::stat_t stat;
  logic load_en;

  rcmc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data), .load_en(load_en), .ctrl(ctrl), .stat(stat)
  );

  rcmc_datapath #(.MAP_ENTRIES(MAP_ENTRIES), .CONST_ENTRIES(CONST_ENTRIES)) u_dp (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .load_en(load_en), .item(in_data), .ctrl(ctrl),
    .stat(stat)
  );
endmodule
`default_nettype wire
